// ----- hdl/matrix4_vector_transform_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the matrix/vector transform unit
// Clocked assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_VECTOR_TRANSFORM_UNIT_DEFINES_SVH
`define MATRIX4_VECTOR_TRANSFORM_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define MVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define MVT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg
// Widths, types and constants of the matrix/vector transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int NUM_LANES  = 4;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_DATA_W = 2 * FIELD_W;
    localparam int PROD_W     = 2 * ELEM_WIDTH;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FUNC_W     = 2;

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [PAIR_W-1:0]     t_pair;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic [CFG_DATA_W-1:0]        t_mat_reg;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_MAT_VEC = 2'd0,
        FUNC_VEC_MAT = 2'd1,
        FUNC_DIAG    = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef struct packed {
        logic load_prod;
        logic load_pair;
    } t_pipe_ctrl;

    localparam t_mat_reg MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

endpackage

// ----- hdl/mvt_lane.sv -----
// ----------------------------------------------------------------------------
// mvt_lane
// One output element: four products, then two pair sums, each registered.
// ----------------------------------------------------------------------------
module mvt_lane
    import mvt_pkg::*;
(
    input  logic       i_clk,
    input  t_pipe_ctrl i_ctrl,
    input  t_elem      i_coef [NUM_LANES],
    input  t_elem      i_vec  [NUM_LANES],
    output t_pair      o_pair [2]
);

    t_prod r_prod [NUM_LANES];
    t_prod n_prod [NUM_LANES];
    t_pair r_pair [2];
    t_pair n_pair [2];

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_prod[k] = PROD_W'(i_coef[k]) * PROD_W'(i_vec[k]);
        end
        n_pair[0] = PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
        n_pair[1] = PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prod) begin
            r_prod <= n_prod;
        end
        if (i_ctrl.load_pair) begin
            r_pair <= n_pair;
        end
    end

    assign o_pair = r_pair;

endmodule

// ----- hdl/mvt_merge.sv -----
// ----------------------------------------------------------------------------
// mvt_merge
// Final add, truncating shift and saturation of all lanes; output register.
// ----------------------------------------------------------------------------
module mvt_merge
    import mvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_pair i_pair [NUM_LANES][2],
    output t_elem o_elem [NUM_LANES],
    output logic  o_sat
);

    localparam t_sum MAX_S = SUM_W'($signed({1'b0, {(ELEM_WIDTH-1){1'b1}}}));
    localparam t_sum MIN_S = SUM_W'($signed({1'b1, {(ELEM_WIDTH-1){1'b0}}}));

    t_sum  sum     [NUM_LANES];
    t_sum  shifted [NUM_LANES];
    t_elem r_elem  [NUM_LANES];
    t_elem n_elem  [NUM_LANES];
    logic  r_sat;
    logic  n_sat;

    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            sum[i]     = SUM_W'(i_pair[i][0]) + SUM_W'(i_pair[i][1]);
            shifted[i] = sum[i] >>> FRAC_BITS;
            if (shifted[i] > MAX_S) begin
                n_elem[i] = MAX_S[ELEM_WIDTH-1:0];
                n_sat     = 1'b1;
            end else if (shifted[i] < MIN_S) begin
                n_elem[i] = MIN_S[ELEM_WIDTH-1:0];
                n_sat     = 1'b1;
            end else begin
                n_elem[i] = shifted[i][ELEM_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_elem <= n_elem;
            r_sat  <= n_sat;
        end
    end

    assign o_elem = r_elem;
    assign o_sat  = r_sat;

endmodule

// ----- hdl/matrix4_vector_transform_unit.sv -----
// ----------------------------------------------------------------------------
// matrix4_vector_transform_unit
// 4x4 signed fixed-point matrix times vector, vector times matrix, or
// diagonal scale, with truncation and per-element saturation.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    tdata x,y,z,w; tuser func
//   m_axis    out        m_axis_tvalid/m_axis_tready    tdata x,y,z,w; tuser saturated
//   cfg       in         i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while m_axis_tready holds; three register
// stages (lane multipliers, lane pair adders, merge stage) lie between the
// edge that accepts an input and its result on m_axis.
// Each stage advances when empty or when the stage after it advances, so
// bubbles collapse under output stalls. Synchronous active-low reset clears
// the stage valid flags and loads the identity matrix. cfg is always ready.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_unit
    import mvt_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x [31:0], y [63:32], z [95:64], w [127:96]
    input  logic [NUM_LANES*FIELD_W-1:0]    s_axis_tdata,
    // func [1:0]
    input  logic [FUNC_W-1:0]               s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // x [31:0], y [63:32], z [95:64], w [127:96]
    output logic [NUM_LANES*FIELD_W-1:0]    m_axis_tdata,
    // saturated [0]
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0]           i_cfg_data
);

`include "matrix4_vector_transform_unit_defines.svh"

    localparam t_elem ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam t_elem ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    t_mat_reg   r_mat [NUM_REGS];
    t_elem      mat   [NUM_LANES][NUM_LANES];
    t_elem      vec   [NUM_LANES];
    t_elem      coef  [NUM_LANES][NUM_LANES];
    t_pair      pair  [NUM_LANES][2];
    t_elem      res   [NUM_LANES];
    logic       res_sat;
    logic [NUM_LANES-1:0] res_clip;
    t_func      func;
    t_pipe_ctrl ctrl;
    logic       r_v1, r_v2, r_v3;
    logic       n_v1, n_v2, n_v3;
    logic       adv1, adv2, adv3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= MAT_RESET;
        end else if (i_cfg_valid) begin
            r_mat[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_LANES; r++) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                mat[r][c] = $signed(r_mat[r*2 + (c >> 1)][(c & 1)*FIELD_W +: ELEM_WIDTH]);
            end
            vec[r] = $signed(s_axis_tdata[r*FIELD_W +: ELEM_WIDTH]);
        end
    end

    assign func = t_func'(s_axis_tuser);

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                unique case (func)
                    FUNC_MAT_VEC: coef[i][k] = mat[i][k];
                    FUNC_VEC_MAT: coef[i][k] = mat[k][i];
                    FUNC_DIAG:    coef[i][k] = (i == k) ? mat[i][i] : '0;
                    FUNC_NONE:    coef[i][k] = '0;
                endcase
            end
        end
    end

    always_comb begin
        adv3 = !r_v3 || m_axis_tready;
        adv2 = !r_v2 || adv3;
        adv1 = !r_v1 || adv2;
        n_v1 = adv1 ? s_axis_tvalid : r_v1;
        n_v2 = adv2 ? r_v1 : r_v2;
        n_v3 = adv3 ? r_v2 : r_v3;
        ctrl.load_prod = adv1;
        ctrl.load_pair = adv2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign s_axis_tready = adv1;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        mvt_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_coef (coef[g]),
            .i_vec  (vec),
            .o_pair (pair[g])
        );
    end

    mvt_merge u_merge (
        .i_clk  (i_clk),
        .i_load (adv3),
        .i_pair (pair),
        .o_elem (res),
        .o_sat  (res_sat)
    );

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            m_axis_tdata[i*FIELD_W +: FIELD_W] = FIELD_W'(res[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            res_clip[i] = (res[i] == ELEM_MAX) || (res[i] == ELEM_MIN);
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tuser  = res_sat;

    `MVT_NEVER(a_stall_only_when_full, !s_axis_tready && !r_v1, "stall with empty stage")
    `MVT_ASSERT(a_accept_fills_stage, (s_axis_tvalid && s_axis_tready) |=> r_v1, "transaction lost")
    `MVT_ASSERT(a_sat_at_limit, (r_v3 && res_sat) |-> (res_clip != '0), "flag without clip")

endmodule

// ----- tb/sv/matrix4_vector_transform_unit_tb.sv -----
// ----------------------------------------------------------------------------
// matrix4_vector_transform_unit_tb
// Self-checking bench for the 4x4 fixed-point transform unit. Directed items
// cover the reset matrix, every mode, saturation both ways and truncation of
// negative fractions. Random streams then run under three idle patterns,
// with the matrix reloaded between bursts. Each result transaction is checked
// against a local bit-accurate model of the matrix arithmetic.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mvt_pkg::*;

    localparam int ACC_W       = 72;
    localparam int PIPE_SLACK  = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int BURST_LEN   = 120;

    typedef logic signed [FIELD_W-1:0]     t_field;
    typedef logic [NUM_LANES*FIELD_W-1:0]  t_vec;

    typedef struct packed {
        logic   saturated;
        t_field out_w;
        t_field out_z;
        t_field out_y;
        t_field out_x;
    } t_xform_res;

    localparam t_elem ELEM_MAX_V = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam t_elem ELEM_MIN_V = ~ELEM_MAX_V;
    localparam t_elem FIX_ONE    = t_elem'(1 << FRAC_BITS);
    localparam t_elem FIX_HALF   = t_elem'(1 << (FRAC_BITS-1));
    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [NUM_LANES*FIELD_W-1:0] s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [NUM_LANES*FIELD_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_mat_reg   mat_regs [NUM_REGS];
    t_elem      mat_plan [NUM_LANES][NUM_LANES];
    t_xform_res pending_results [$];
    int         mismatches = 0;
    int         src_idle_pct = 14;
    int         sink_idle_pct = 79;
    int         stall_cycles = 0;

    matrix4_vector_transform_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_elem mat_entry(input int r, input int c);
        t_mat_reg word;
        word = mat_regs[r*2 + c/2];
        return word[(c%2)*FIELD_W +: ELEM_WIDTH];
    endfunction

    function automatic t_mat_reg pack_pair(input int r, input int h);
        return {t_field'(mat_plan[r][2*h+1]), t_field'(mat_plan[r][2*h])};
    endfunction

    function automatic t_xform_res predict_transform(input t_func f, input t_vec vec);
        t_xform_res res;
        t_elem v [NUM_LANES];
        t_elem e;
        t_field lane [NUM_LANES];
        logic signed [ACC_W-1:0] acc, a, b;
        res = '0;
        for (int k = 0; k < NUM_LANES; k++)
            v[k] = vec[k*FIELD_W +: ELEM_WIDTH];
        for (int i = 0; i < NUM_LANES; i++) begin
            acc = '0;
            for (int k = 0; k < NUM_LANES; k++) begin
                a = '0;
                b = '0;
                case (f)
                    FUNC_MAT_VEC: begin
                        a = mat_entry(i, k);
                        b = v[k];
                    end
                    FUNC_VEC_MAT: begin
                        a = v[k];
                        b = mat_entry(k, i);
                    end
                    FUNC_DIAG: begin
                        if (k == i) begin
                            a = mat_entry(i, i);
                            b = v[i];
                        end
                    end
                    default: ;
                endcase
                acc = acc + a * b;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > ACC_MAX) begin
                e = ELEM_MAX_V;
                res.saturated = 1'b1;
            end else if (acc < ACC_MIN) begin
                e = ELEM_MIN_V;
                res.saturated = 1'b1;
            end else begin
                e = acc[ELEM_WIDTH-1:0];
            end
            lane[i] = e;
        end
        res.out_x = lane[0];
        res.out_y = lane[1];
        res.out_z = lane[2];
        res.out_w = lane[3];
        return res;
    endfunction

    function automatic t_elem rand_elem(input int wild_pct);
        t_elem mag;
        if ($urandom_range(99) < wild_pct) begin
            case ($urandom_range(5))
                0: return ELEM_MAX_V;
                1: return ELEM_MIN_V;
                2: return FIX_ONE;
                3: return -FIX_ONE;
                default: return t_elem'($urandom);
            endcase
        end
        mag = t_elem'($urandom_range(0, 1 << (FRAC_BITS+3)));
        return ($urandom_range(1) != 0) ? -mag : mag;
    endfunction

    function automatic t_vec make_vec(input t_elem x, input t_elem y,
                                      input t_elem z, input t_elem w);
        return {t_field'(w), t_field'(z), t_field'(y), t_field'(x)};
    endfunction

    function automatic t_vec rand_vec(input int wild_pct);
        return make_vec(rand_elem(wild_pct), rand_elem(wild_pct),
                        rand_elem(wild_pct), rand_elem(wild_pct));
    endfunction

    task automatic fill_plan(input t_elem diag, input t_elem off);
        for (int r = 0; r < NUM_LANES; r++)
            for (int c = 0; c < NUM_LANES; c++)
                mat_plan[r][c] = (r == c) ? diag : off;
    endtask

    task automatic load_matrix();
        t_mat_reg word;
        for (int r = 0; r < NUM_LANES; r++) begin
            for (int h = 0; h < 2; h++) begin
                word = pack_pair(r, h);
                i_cfg_valid <= 1'b1;
                i_cfg_index <= CFG_IDX_W'(r*2 + h);
                i_cfg_data  <= word;
                do @(posedge i_clk); while (!o_cfg_ready);
                mat_regs[r*2 + h] = word;
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_vector(input t_func f, input t_vec vec);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vec;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_transform(f, vec));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic test_identity_after_reset();
        send_vector(FUNC_MAT_VEC, make_vec(ELEM_MAX_V, ELEM_MIN_V, FIX_ONE, -1));
        send_vector(FUNC_VEC_MAT, make_vec(-FIX_ONE, ELEM_MAX_V, ELEM_MIN_V, 1));
        send_vector(FUNC_DIAG, rand_vec(50));
        send_vector(FUNC_NONE, make_vec(ELEM_MAX_V, ELEM_MAX_V, ELEM_MIN_V, ELEM_MIN_V));
        wait_idle();
    endtask

    task automatic test_saturation_extremes();
        fill_plan(ELEM_MAX_V, ELEM_MAX_V);
        load_matrix();
        send_vector(FUNC_MAT_VEC, make_vec(ELEM_MAX_V, ELEM_MAX_V, ELEM_MAX_V, ELEM_MAX_V));
        send_vector(FUNC_VEC_MAT, make_vec(ELEM_MIN_V, ELEM_MIN_V, ELEM_MIN_V, ELEM_MIN_V));
        send_vector(FUNC_DIAG, make_vec(ELEM_MAX_V, ELEM_MIN_V, 0, 1));
        send_vector(FUNC_NONE, make_vec(ELEM_MIN_V, ELEM_MIN_V, ELEM_MIN_V, ELEM_MIN_V));
        wait_idle();
        fill_plan(ELEM_MIN_V, ELEM_MIN_V);
        load_matrix();
        send_vector(FUNC_MAT_VEC, make_vec(ELEM_MIN_V, ELEM_MIN_V, ELEM_MIN_V, ELEM_MIN_V));
        send_vector(FUNC_DIAG, make_vec(ELEM_MAX_V, ELEM_MAX_V, ELEM_MIN_V, -1));
        send_vector(FUNC_VEC_MAT, make_vec(0, 0, 0, 0));
        wait_idle();
    endtask

    task automatic test_truncation_rounding();
        fill_plan(FIX_HALF, 0);
        load_matrix();
        send_vector(FUNC_DIAG, make_vec(1, -1, 3, -3));
        send_vector(FUNC_MAT_VEC, make_vec(-1, 1, -3, 3));
        wait_idle();
        fill_plan(FIX_HALF, -FIX_HALF);
        load_matrix();
        send_vector(FUNC_VEC_MAT, make_vec(1, -1, FIX_ONE, -FIX_ONE));
        send_vector(FUNC_MAT_VEC, make_vec(-1, -1, -1, 1));
        wait_idle();
    endtask

    task automatic test_random_transforms(input int n_items);
        int wild;
        for (int i = 0; i < n_items; i++) begin
            if (i % BURST_LEN == 0) begin
                wait_idle();
                wild = ($urandom_range(1) != 0) ? 10 : 70;
                for (int r = 0; r < NUM_LANES; r++)
                    for (int c = 0; c < NUM_LANES; c++)
                        mat_plan[r][c] = rand_elem(wild);
                load_matrix();
            end
            send_vector(t_func'($urandom_range(3)), rand_vec(20));
            if ($urandom_range(99) == 0)
                wait_idle();
        end
        wait_idle();
    endtask

    task automatic check_field(input string name, input t_field want, input t_field got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_xform_res got;
        t_xform_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_x     = m_axis_tdata[0*FIELD_W +: FIELD_W];
            got.out_y     = m_axis_tdata[1*FIELD_W +: FIELD_W];
            got.out_z     = m_axis_tdata[2*FIELD_W +: FIELD_W];
            got.out_w     = m_axis_tdata[3*FIELD_W +: FIELD_W];
            got.saturated = m_axis_tuser[0];
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_x", want.out_x, got.out_x);
                check_field("out_y", want.out_y, got.out_y);
                check_field("out_z", want.out_z, got.out_z);
                check_field("out_w", want.out_w, got.out_w);
                check_field("saturated", t_field'({1'b0, want.saturated}),
                            t_field'({1'b0, got.saturated}));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("matrix4_vector_transform_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        fill_plan(FIX_ONE, 0);
        for (int r = 0; r < NUM_LANES; r++)
            for (int h = 0; h < 2; h++)
                mat_regs[r*2 + h] = pack_pair(r, h);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_after_reset();
        test_saturation_extremes();
        test_truncation_rounding();
        test_random_transforms(360);

        src_idle_pct  = 79;
        sink_idle_pct = 14;
        test_random_transforms(360);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_transforms(360);

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("matrix4_vector_transform_unit_tb OK");
        end else begin
            $display("matrix4_vector_transform_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
